// File: src/rtt_pkg.sv
// Shared constants, codes and stage types of the three-table reciprocal square root.
`default_nettype none
package rtt_pkg;

   localparam int FRAC_BITS   = 23;
   localparam int INDEX_BITS  = 8;
   localparam int CORR_BITS   = 10;
   localparam int TABLE_DEPTH = 512;

   localparam int ADDR_BITS  = $clog2(TABLE_DEPTH);
   localparam int SIG_BITS   = FRAC_BITS + 2;
   localparam int LOW_BASE   = FRAC_BITS - INDEX_BITS;
   localparam int LOW_MAX    = LOW_BASE + 1;
   localparam int CORR_SHIFT = LOW_BASE - CORR_BITS;
   localparam int Q_SHIFT    = 18 - (FRAC_BITS - 23);
   localparam int WORD_BITS  = 32;
   localparam int BYTE_BITS  = 8;
   localparam int Z_BITS     = 2 * CORR_BITS;
   localparam int QPROD_BITS = Z_BITS + BYTE_BITS;
   localparam int LPROD_BITS = WORD_BITS + LOW_MAX;
   localparam int ENTRY_BITS = 2 * WORD_BITS + BYTE_BITS;
   localparam int REQ_DATA_BITS = 112;

   typedef enum logic [0:0] {
      REQ_LOAD    = 1'b0,
      REQ_COMPUTE = 1'b1
   } req_kind_type;

   // operand fields held while the tables are read
   typedef struct packed {
      logic                half;
      logic [LOW_MAX-1:0]  low;
      logic [Z_BITS-1:0]   z;
   } split_type;

   // one table entry as stored in the memory
   typedef struct packed {
      logic [BYTE_BITS-1:0] corr;
      logic [WORD_BITS-1:0] slope;
      logic [WORD_BITS-1:0] base;
   } entry_type;

endpackage
`default_nettype wire

// File: src/rtt_ram.sv
// Generic single-write, single-read memory with registered read data.
`default_nettype none
module rtt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                      clock,
   input  wire                      wr_en,
   input  wire  [$clog2(DEPTH)-1:0] wr_addr,
   input  wire  [WIDTH-1:0]         wr_data,
   input  wire                      rd_en,
   input  wire  [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: src/rtt_split.sv
// Operand split: table index, low field and correction term x*~x.
`default_nettype none
module rtt_split (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                adv,
   input  wire                                take,
   input  wire  [rtt_pkg::SIG_BITS-1:0]       sig,
   output logic [rtt_pkg::ADDR_BITS-1:0]      idx,
   output rtt_pkg::split_type                 split,
   output logic                               valid
);

   logic                             half;
   logic [rtt_pkg::INDEX_BITS-1:0]   mid;
   logic [rtt_pkg::CORR_BITS-1:0]    xc;
   logic [rtt_pkg::CORR_BITS-1:0]    xc_inv;
   rtt_pkg::split_type               split_in;
   rtt_pkg::split_type               split_ff;
   logic                             valid_in;
   logic                             valid_ff;

   always_comb begin
      half = sig[rtt_pkg::FRAC_BITS+1];
      if (half) begin
         mid = sig[rtt_pkg::LOW_BASE+1 +: rtt_pkg::INDEX_BITS];
         xc  = sig[rtt_pkg::CORR_SHIFT+1 +: rtt_pkg::CORR_BITS];
         split_in.low = sig[rtt_pkg::LOW_MAX-1:0];
      end else begin
         mid = sig[rtt_pkg::LOW_BASE +: rtt_pkg::INDEX_BITS];
         xc  = sig[rtt_pkg::CORR_SHIFT +: rtt_pkg::CORR_BITS];
         split_in.low = {1'b0, sig[rtt_pkg::LOW_BASE-1:0]};
      end
      // complement taken at field width before widening
      xc_inv = ~xc;
      split_in.half = half;
      split_in.z    = rtt_pkg::Z_BITS'(xc) * rtt_pkg::Z_BITS'(xc_inv);
      idx = rtt_pkg::ADDR_BITS'({half, mid});
      valid_in = adv ? take : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         split_ff <= split_in;
      end
   end

   assign split = split_ff;
   assign valid = valid_ff;

endmodule
`default_nettype wire

// File: src/rtt_combine.sv
// Linear and quadratic products and the final difference.
`default_nettype none
module rtt_combine (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                adv,
   input  wire                                in_valid,
   input  rtt_pkg::split_type                 split,
   input  rtt_pkg::entry_type                 entry,
   output logic [rtt_pkg::WORD_BITS-1:0]      result,
   output logic                               valid
);

   logic [rtt_pkg::LPROD_BITS-1:0] lprod_in, lprod_ff;
   logic [rtt_pkg::QPROD_BITS-1:0] qprod_in, qprod_ff;
   logic [rtt_pkg::WORD_BITS-1:0]  base_ff;
   logic                           half_ff;
   logic                           valid_in, valid_ff;
   logic [rtt_pkg::WORD_BITS-1:0]  lin;
   logic [rtt_pkg::WORD_BITS-1:0]  quad;

   always_comb begin
      lprod_in = rtt_pkg::LPROD_BITS'(entry.slope) * rtt_pkg::LPROD_BITS'(split.low);
      qprod_in = rtt_pkg::QPROD_BITS'(split.z) * rtt_pkg::QPROD_BITS'(entry.corr);
      valid_in = adv ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lprod_ff <= lprod_in;
         qprod_ff <= qprod_in;
         base_ff  <= entry.base;
         half_ff  <= split.half;
      end
   end

   // low field is one bit wider in the upper half, so drop one more bit
   always_comb begin
      if (half_ff) begin
         lin = lprod_ff[rtt_pkg::LOW_MAX +: rtt_pkg::WORD_BITS];
      end else begin
         lin = lprod_ff[rtt_pkg::LOW_BASE +: rtt_pkg::WORD_BITS];
      end
      quad   = rtt_pkg::WORD_BITS'(qprod_ff >> rtt_pkg::Q_SHIFT);
      result = base_ff - lin - quad;
   end

   assign valid = valid_ff;

endmodule
`default_nettype wire

// File: src/three_table_rsqrt_top.sv
// Path: a compute item passes the split register and table read, the combine register, then the output register to rsp.
// Throughput: one item per cycle; loads use the table write port, computes the read
// port, so the two never contend. Whole pipeline holds while rsp is stalled.
// Load items write the table at their accept edge and produce no result.
// Reset clears all valid flags; table contents stay undefined until loaded.
`default_nettype none
module three_table_rsqrt_top (
   input  wire          clock,
   input  wire          reset,
   input  wire          req_tvalid,
   output logic         req_tready,
   // [8:0] entry_index, [40:9] base_word, [72:41] slope_word,
   // [80:73] correction_byte, [105:81] significand, [111:106] zero
   input  wire  [111:0] req_tdata,
   // [0] req_type
   input  wire  [0:0]   req_tuser,
   output logic         rsp_tvalid,
   input  wire          rsp_tready,
   // [31:0] root_recip
   output logic [31:0]  rsp_tdata
);

   // request fields
   logic [rtt_pkg::ADDR_BITS-1:0]  entry_index;
   rtt_pkg::entry_type             wr_entry;
   logic [rtt_pkg::SIG_BITS-1:0]   significand;
   logic                           is_compute;

   // pipeline control: every stage moves when the output register can take data
   logic adv;
   logic accept;

   logic [rtt_pkg::ADDR_BITS-1:0]  rd_idx;
   rtt_pkg::split_type             split;
   logic                           split_valid;
   rtt_pkg::entry_type             rd_entry;
   logic [rtt_pkg::ENTRY_BITS-1:0] rd_word;
   logic [rtt_pkg::WORD_BITS-1:0]  result;
   logic                           result_valid;

   logic                           rsp_valid_in, rsp_valid_ff;
   logic [rtt_pkg::WORD_BITS-1:0]  rsp_data_ff;

   assign entry_index    = req_tdata[8:0];
   assign wr_entry.base  = req_tdata[40:9];
   assign wr_entry.slope = req_tdata[72:41];
   assign wr_entry.corr  = req_tdata[80:73];
   assign significand    = req_tdata[105:81];
   assign is_compute     = (req_tuser == 1'(rtt_pkg::REQ_COMPUTE));

   assign adv        = !rsp_valid_ff || rsp_tready;
   assign req_tready = adv;
   assign accept     = req_tvalid && adv;

   rtt_split u_split (
      .clock (clock),
      .reset (reset),
      .adv   (adv),
      .take  (accept && is_compute),
      .sig   (significand),
      .idx   (rd_idx),
      .split (split),
      .valid (split_valid)
   );

   // one memory holds all three tables side by side; a compute right after a
   // load of the same entry reads after the write edge, so no forwarding
   rtt_ram #(
      .WIDTH (rtt_pkg::ENTRY_BITS),
      .DEPTH (rtt_pkg::TABLE_DEPTH)
   ) u_tables (
      .clock   (clock),
      .wr_en   (accept && !is_compute),
      .wr_addr (entry_index),
      .wr_data (wr_entry),
      .rd_en   (adv),
      .rd_addr (rd_idx),
      .rd_data (rd_word)
   );

   assign rd_entry = rd_word;

   rtt_combine u_combine (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .in_valid (split_valid),
      .split    (split),
      .entry    (rd_entry),
      .result   (result),
      .valid    (result_valid)
   );

   // output register
   always_comb begin
      rsp_valid_in = adv ? result_valid : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // accepted compute enters the split stage
   a_compute_enters: assert property (@(posedge clock) disable iff (reset)
      (accept && is_compute) |=> split_valid)
      else $error("accepted compute item missing in split stage");

   // a load never occupies the pipeline
   a_load_no_result: assert property (@(posedge clock) disable iff (reset)
      (accept && !is_compute) |=> !split_valid)
      else $error("load item entered the compute pipeline");

   // stalled pipeline keeps its valid flags
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(split_valid) && $stable(result_valid)))
      else $error("pipeline changed during stall");

   // a valid result waiting in a stall keeps its value
   a_stall_result: assert property (@(posedge clock) disable iff (reset)
      (!adv && result_valid) |=> $stable(result))
      else $error("result changed during stall");

endmodule
`default_nettype wire
